[src/modbus_slave_register_responder_unit_macros.svh]
// assertion macros for the modbus register responder checker
// expects clk and rst_n in the scope of each use
`ifndef MODBUS_SLAVE_REGISTER_RESPONDER_UNIT_MACROS_SVH
`define MODBUS_SLAVE_REGISTER_RESPONDER_UNIT_MACROS_SVH

// same-cycle implication
`define MBSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mbsr_pkg.sv]
// shared types, codes and helper functions of the modbus register responder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbsr_pkg;

    localparam int REGISTER_COUNT_DEF = 16;
    localparam int BANK_IDX_W = 4;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic MODE_RTU   = 1'b0;
    localparam logic MODE_ASCII = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ADDR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_COUNT = 2'd2;

    localparam logic [1:0] CFG_FRAME_MODE = 2'd0;
    localparam logic [1:0] CFG_SLAVE_ADDR = 2'd1;

    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_HEAD,
        S_DATA,
        S_TAIL
    } seq_state_t;

    // one character (or one error) handed from the sequencer to the packer
    typedef struct packed {
        logic       valid;
        logic       err;
        logic [1:0] status;
        logic [7:0] ch;
        logic       last;
    } emit_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        unique case (nib)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            4'hF: c = 8'h46;
        endcase
        return c;
    endfunction

    // reflected crc16, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [15:0] reg_reset_value(input logic [BANK_IDX_W-1:0] i);
        logic [15:0] v;
        unique case (i)
            4'd0:    v = 16'd100;
            4'd1:    v = 16'd200;
            4'd2:    v = 16'd300;
            4'd3:    v = 16'd400;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/mbsr_bank.sv]
// holding register bank: synchronous memory with a registered read port
// entries not written since reset read as their reset value; uses mbsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbsr_bank #(
    parameter int REGISTER_COUNT = mbsr_pkg::REGISTER_COUNT_DEF,
    parameter int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire logic [15:0]      wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_idx,
    output logic      [15:0]      rd_data
);
    import mbsr_pkg::*;

    logic [15:0]               mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] written_reg;
    logic [15:0]               rd_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            written_reg <= '0;
        else if (wr_en)
            written_reg[wr_idx] <= 1'b1;
    end

    always_ff @(posedge clk) begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
    end

    always_ff @(posedge clk) begin
        if (rd_en)
        begin
            if (written_reg[rd_idx])
                rd_data_reg <= mem[rd_idx];
            else
                rd_data_reg <= reg_reset_value(BANK_IDX_W'(rd_idx));
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/mbsr_seq.sv]
// request sequencer: checks a request, updates the bank and walks the frame
// one character per step with crc16 / lrc; uses mbsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbsr_seq #(
    parameter int REGISTER_COUNT = mbsr_pkg::REGISTER_COUNT_DEF,
    parameter int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             opcode,
    input  wire logic [15:0]      reg_addr,
    input  wire logic [15:0]      write_value,
    input  wire logic [7:0]       read_count,
    input  wire logic             frame_mode,
    input  wire logic [7:0]       slave_address,
    output mbsr_pkg::emit_t       emit,
    input  wire logic             emit_ready,
    output logic                  wr_en,
    output logic      [IDX_W-1:0] wr_idx,
    output logic      [15:0]      wr_data,
    output logic                  rd_en,
    output logic      [IDX_W-1:0] rd_idx,
    input  wire logic [15:0]      rd_data
);
    import mbsr_pkg::*;

    seq_state_t  state_reg, state_next;
    logic        op_reg, op_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] value_reg, value_next;
    logic [4:0]  count_reg, count_next;
    logic [5:0]  bi_reg, bi_next;
    logic        nib_reg, nib_next;
    logic        fetched_reg, fetched_next;
    logic [1:0]  tail_reg, tail_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sum_reg, sum_next;
    logic [1:0]  status_reg, status_next;

    logic        accept;
    logic        cnt_bad, span_bad, waddr_bad;
    logic [5:0]  last_bi;
    logic [5:0]  word_off;
    logic [15:0] rd_addr_full;
    logic        fetch_needed;
    logic [7:0]  cur_byte;
    logic [7:0]  lrc;
    logic        byte_done;
    logic        tail_last;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign cnt_bad   = (read_count == 8'd0) || ({1'b0, read_count} > 9'(REGISTER_COUNT));
    assign span_bad  = ({1'b0, reg_addr} + {9'd0, read_count}) > 17'(REGISTER_COUNT);
    assign waddr_bad = reg_addr >= 16'(REGISTER_COUNT);

    assign wr_en   = accept && (opcode == OP_WRITE) && !waddr_bad;
    assign wr_idx  = reg_addr[IDX_W-1:0];
    assign wr_data = write_value;

    assign last_bi      = (op_reg == OP_WRITE) ? 6'd5 : ({count_reg, 1'b0} + 6'd2);
    assign word_off     = (bi_reg - 6'd3) >> 1;
    assign rd_addr_full = addr_reg + {10'd0, word_off};
    assign rd_idx       = rd_addr_full[IDX_W-1:0];
    assign fetch_needed = (op_reg == OP_READ) && (bi_reg >= 6'd3) && bi_reg[0] && !fetched_reg;
    assign lrc          = 8'd0 - sum_reg;
    assign byte_done    = (frame_mode == MODE_RTU) || nib_reg;
    assign tail_last    = (frame_mode == MODE_ASCII) ? (tail_reg == 2'd3) : (tail_reg == 2'd1);

    always_comb begin
        priority if (bi_reg == 6'd0)
            cur_byte = slave_address;
        else if (bi_reg == 6'd1)
            cur_byte = (op_reg == OP_WRITE) ? FC_WRITE_SINGLE : FC_READ_HOLDING;
        else if (op_reg == OP_WRITE)
        begin
            priority if (bi_reg == 6'd2)
                cur_byte = addr_reg[15:8];
            else if (bi_reg == 6'd3)
                cur_byte = addr_reg[7:0];
            else if (bi_reg == 6'd4)
                cur_byte = value_reg[15:8];
            else
                cur_byte = value_reg[7:0];
        end
        else if (bi_reg == 6'd2)
            cur_byte = {2'd0, count_reg, 1'b0};
        else if (bi_reg[0])
            cur_byte = rd_data[15:8];
        else
            cur_byte = rd_data[7:0];
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        bi_next      = bi_reg;
        nib_next     = nib_reg;
        fetched_next = fetched_reg;
        tail_next    = tail_reg;
        crc_next     = crc_reg;
        sum_next     = sum_reg;
        status_next  = status_reg;
        rd_en        = 1'b0;
        emit         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = opcode;
                    addr_next    = reg_addr;
                    value_next   = write_value;
                    count_next   = read_count[4:0];
                    bi_next      = '0;
                    nib_next     = 1'b0;
                    fetched_next = 1'b0;
                    tail_next    = '0;
                    crc_next     = CRC_INIT;
                    sum_next     = '0;
                    priority if (opcode == OP_WRITE && waddr_bad)
                    begin
                        status_next = STATUS_BAD_ADDR;
                        state_next  = S_ERR;
                    end
                    else if (opcode == OP_READ && cnt_bad)
                    begin
                        status_next = STATUS_BAD_COUNT;
                        state_next  = S_ERR;
                    end
                    else if (opcode == OP_READ && span_bad)
                    begin
                        status_next = STATUS_BAD_ADDR;
                        state_next  = S_ERR;
                    end
                    else
                        state_next = (frame_mode == MODE_ASCII) ? S_HEAD : S_DATA;
                end
            end
            S_ERR:
            begin
                emit.valid  = 1'b1;
                emit.err    = 1'b1;
                emit.status = status_reg;
                emit.last   = 1'b1;
                if (emit_ready)
                    state_next = S_IDLE;
            end
            S_HEAD:
            begin
                emit.valid = 1'b1;
                emit.ch    = CH_COLON;
                if (emit_ready)
                    state_next = S_DATA;
            end
            S_DATA:
            begin
                if (fetch_needed)
                begin
                    rd_en        = 1'b1;
                    fetched_next = 1'b1;
                end
                else
                begin
                    emit.valid = 1'b1;
                    if (frame_mode == MODE_ASCII)
                        emit.ch = hex_char(nib_reg ? cur_byte[3:0] : cur_byte[7:4]);
                    else
                        emit.ch = cur_byte;
                    if (emit_ready)
                    begin
                        if (byte_done)
                        begin
                            crc_next     = crc16_byte(crc_reg, cur_byte);
                            sum_next     = sum_reg + cur_byte;
                            fetched_next = 1'b0;
                            nib_next     = 1'b0;
                            if (bi_reg == last_bi)
                            begin
                                tail_next  = '0;
                                state_next = S_TAIL;
                            end
                            else
                                bi_next = bi_reg + 6'd1;
                        end
                        else
                            nib_next = 1'b1;
                    end
                end
            end
            S_TAIL:
            begin
                emit.valid = 1'b1;
                emit.last  = tail_last;
                if (frame_mode == MODE_ASCII)
                begin
                    unique case (tail_reg)
                        2'd0: emit.ch = hex_char(lrc[7:4]);
                        2'd1: emit.ch = hex_char(lrc[3:0]);
                        2'd2: emit.ch = CH_CR;
                        2'd3: emit.ch = CH_LF;
                    endcase
                end
                else
                    emit.ch = tail_reg[0] ? crc_reg[15:8] : crc_reg[7:0];
                if (emit_ready)
                begin
                    if (tail_last)
                        state_next = S_IDLE;
                    else
                        tail_next = tail_reg + 2'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk) begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        value_reg   <= value_next;
        count_reg   <= count_next;
        bi_reg      <= bi_next;
        nib_reg     <= nib_next;
        fetched_reg <= fetched_next;
        tail_reg    <= tail_next;
        crc_reg     <= crc_next;
        sum_reg     <= sum_next;
        status_reg  <= status_next;
    end

endmodule

`default_nettype wire

[src/mbsr_packer.sv]
// result packer: pairs frame characters into results and holds the output register
// uses mbsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbsr_packer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mbsr_pkg::emit_t emit,
    output logic                 emit_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           out_status,
    output logic [7:0]           out_first,
    output logic [7:0]           out_second,
    output logic [1:0]           out_count,
    output logic                 out_last
);
    import mbsr_pkg::*;

    logic       valid_reg, valid_next;
    logic       have_first_reg, have_first_next;
    logic [7:0] held_reg, held_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [1:0] count_reg, count_next;
    logic       last_reg, last_next;
    logic       take;
    logic       load;

    assign emit_ready = !valid_reg || out_ready;
    assign take       = emit.valid && emit_ready;

    always_comb begin
        have_first_next = have_first_reg;
        held_next       = held_reg;
        status_next     = status_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        load            = 1'b0;
        if (take)
        begin
            priority if (emit.err)
            begin
                load        = 1'b1;
                status_next = emit.status;
                first_next  = '0;
                second_next = '0;
                count_next  = 2'd0;
                last_next   = 1'b1;
            end
            else if (have_first_reg)
            begin
                load            = 1'b1;
                have_first_next = 1'b0;
                status_next     = STATUS_OK;
                first_next      = held_reg;
                second_next     = emit.ch;
                count_next      = 2'd2;
                last_next       = emit.last;
            end
            else if (emit.last)
            begin
                load        = 1'b1;
                status_next = STATUS_OK;
                first_next  = emit.ch;
                second_next = '0;
                count_next  = 2'd1;
                last_next   = 1'b1;
            end
            else
            begin
                have_first_next = 1'b1;
                held_next       = emit.ch;
            end
        end
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            have_first_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            have_first_reg <= have_first_next;
        end
    end

    always_ff @(posedge clk) begin
        held_reg   <= held_next;
        status_reg <= status_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;
    assign out_count  = count_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

[src/modbus_slave_register_responder_unit.sv]
// Modbus slave answering read holding registers (FC03) and write single register
// (FC06) requests from a bank of 16-bit registers, in RTU (crc16) or ASCII (lrc)
// framing. One request is taken at a time; its answer leaves as results of up to
// two frame bytes or characters, the final one flagged by tlast. The sequencer
// produces one frame character per cycle while the packer can take it, and reads
// each register from the bank in a step of its own. A request keeps the input
// busy while its whole frame is produced, a rejected request only while its error
// result is handed on, and a low m_axis_tready stalls it further. The next request
// is taken as soon as the last result sits in the output register.
// Depends on mbsr_pkg, mbsr_bank, mbsr_seq and mbsr_packer.
`timescale 1ns / 1ps
`default_nettype none

module modbus_slave_register_responder_unit #(
    parameter int REGISTER_COUNT = mbsr_pkg::REGISTER_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // reg_addr[15:0], write_value[31:16], read_count[39:32]
    input  wire logic [39:0] s_axis_tdata,
    // opcode[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // first_byte[7:0], second_byte[15:8], byte_count[17:16], zero[23:18]
    output logic      [23:0] m_axis_tdata,
    // status[1:0]
    output logic      [1:0]  m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import mbsr_pkg::*;

    localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    logic       frame_mode_reg, frame_mode_next;
    logic [7:0] slave_reg, slave_next;

    emit_t             emit;
    logic              emit_ready;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [15:0]       rd_data;
    logic [7:0]        out_first;
    logic [7:0]        out_second;
    logic [1:0]        out_count;

    assign cfg_ready = 1'b1;

    always_comb begin
        frame_mode_next = frame_mode_reg;
        slave_next      = slave_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_MODE: frame_mode_next = cfg_data[0];
                CFG_SLAVE_ADDR: slave_next      = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            frame_mode_reg <= MODE_RTU;
            slave_reg      <= 8'd1;
        end
        else
        begin
            frame_mode_reg <= frame_mode_next;
            slave_reg      <= slave_next;
        end
    end

    mbsr_bank #(
        .REGISTER_COUNT(REGISTER_COUNT),
        .IDX_W         (IDX_W)
    ) u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_idx (wr_idx),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_idx (rd_idx),
        .rd_data(rd_data)
    );

    mbsr_seq #(
        .REGISTER_COUNT(REGISTER_COUNT),
        .IDX_W         (IDX_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .opcode       (s_axis_tuser),
        .reg_addr     (s_axis_tdata[15:0]),
        .write_value  (s_axis_tdata[31:16]),
        .read_count   (s_axis_tdata[39:32]),
        .frame_mode   (frame_mode_reg),
        .slave_address(slave_reg),
        .emit         (emit),
        .emit_ready   (emit_ready),
        .wr_en        (wr_en),
        .wr_idx       (wr_idx),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_idx       (rd_idx),
        .rd_data      (rd_data)
    );

    mbsr_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .emit_ready(emit_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_status(m_axis_tuser),
        .out_first (out_first),
        .out_second(out_second),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_count, out_second, out_first};

endmodule

`default_nettype wire

[src/mbsr_checker.sv]
// port-level checker for the modbus register responder, bound to the top level
// uses the assertion macros header and mbsr_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_slave_register_responder_unit_macros.svh"

module mbsr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    import mbsr_pkg::*;

    `MBSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
    `MBSR_ASSERT_NOW(a_err_empty, m_axis_tvalid, (m_axis_tuser != STATUS_OK) == (m_axis_tdata[17:16] == 2'd0), "status and byte count disagree")
    `MBSR_ASSERT_NOW(a_err_last, m_axis_tvalid && m_axis_tuser != STATUS_OK, m_axis_tlast, "error result not last")
    `MBSR_ASSERT_NOW(a_odd_last, m_axis_tvalid && m_axis_tdata[17:16] == 2'd1, m_axis_tlast && m_axis_tdata[15:8] == 8'd0, "single-byte result not final")
    `MBSR_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

endmodule

bind modbus_slave_register_responder_unit mbsr_checker u_mbsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for modbus_slave_register_responder_unit, fc03 and fc06 in rtu and ascii
// a local model of the register bank and framing predicts every result transfer
// depends on mbsr_pkg and the responder rtl only
`timescale 1ns / 1ps

module testbench;
    import mbsr_pkg::*;

    localparam int REGS = REGISTER_COUNT_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_ITEMS = 66;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [1:0] nbytes;
        logic       is_last;
    } chunk_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    chunk_t      response_chunks[$];
    logic [15:0] holding_regs [REGS];
    logic        mode_now;
    logic [7:0]  station_addr;
    bit          gaps_on = 1'b1;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;

    modbus_slave_register_responder_unit #(
        .REGISTER_COUNT(REGS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h37 + {4'd0, nib};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_status(input logic [1:0] code);
        chunk_t c;
        c = '0;
        c.status = code;
        c.is_last = 1'b1;
        response_chunks.push_back(c);
    endtask

    // builds the response frame (or an error result) and splits it into transfers of up to two bytes
    task automatic build_response(input logic op, input logic [15:0] addr,
                                  input logic [15:0] value, input logic [7:0] count);
        logic [7:0]  frame[$];
        logic [7:0]  line[$];
        logic [15:0] crc;
        logic [15:0] word;
        logic [7:0]  sum;
        chunk_t      c;
        int          span;
        int          k;
        frame.push_back(station_addr);
        if (op == OP_WRITE)
        begin
            if (addr >= REGS)
            begin
                push_status(STATUS_BAD_ADDR);
                return;
            end
            holding_regs[addr] = value;
            frame.push_back(FC_WRITE_SINGLE);
            frame.push_back(addr[15:8]);
            frame.push_back(addr[7:0]);
            frame.push_back(value[15:8]);
            frame.push_back(value[7:0]);
        end
        else
        begin
            span = int'(addr) + int'(count);
            if (count == 8'd0 || count > REGS)
            begin
                push_status(STATUS_BAD_COUNT);
                return;
            end
            if (span > REGS)
            begin
                push_status(STATUS_BAD_ADDR);
                return;
            end
            frame.push_back(FC_READ_HOLDING);
            frame.push_back({count[6:0], 1'b0});
            for (k = 0; k < count; k++)
            begin
                word = holding_regs[int'(addr) + k];
                frame.push_back(word[15:8]);
                frame.push_back(word[7:0]);
            end
        end

        if (mode_now == MODE_RTU)
        begin
            crc = CRC_INIT;
            for (k = 0; k < frame.size(); k++)
            begin
                crc = crc ^ {8'd0, frame[k]};
                repeat (8)
                    crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
                line.push_back(frame[k]);
            end
            line.push_back(crc[7:0]);
            line.push_back(crc[15:8]);
        end
        else
        begin
            sum = 8'd0;
            line.push_back(CH_COLON);
            for (k = 0; k < frame.size(); k++)
            begin
                sum = sum + frame[k];
                line.push_back(hex_ascii(frame[k][7:4]));
                line.push_back(hex_ascii(frame[k][3:0]));
            end
            sum = 8'd0 - sum;
            line.push_back(hex_ascii(sum[7:4]));
            line.push_back(hex_ascii(sum[3:0]));
            line.push_back(CH_CR);
            line.push_back(CH_LF);
        end

        for (k = 0; k < line.size(); k += 2)
        begin
            c.status = STATUS_OK;
            c.byte0 = line[k];
            if (k + 1 < line.size())
            begin
                c.byte1 = line[k + 1];
                c.nbytes = 2'd2;
            end
            else
            begin
                c.byte1 = 8'd0;
                c.nbytes = 2'd1;
            end
            c.is_last = (k + 2 >= line.size());
            response_chunks.push_back(c);
        end
    endtask

    task automatic send_request(input logic op, input logic [15:0] addr,
                                input logic [15:0] value, input logic [7:0] count);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {count, value, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        build_response(op, addr, value, count);
    endtask

    // mostly well-formed requests, some with out-of-range fields
    task automatic send_random_request();
        int          r;
        int          n;
        logic [15:0] addr;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_request(OP_WRITE, 16'($urandom_range(0, REGS - 1)), 16'($urandom),
                         8'($urandom));
        else if (r < 85)
        begin
            n = ($urandom_range(0, 9) == 0) ? REGS : $urandom_range(1, 6);
            send_request(OP_READ, 16'($urandom_range(0, REGS - n)), 16'($urandom), 8'(n));
        end
        else
        begin
            addr = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            send_request(($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE, addr,
                         16'($urandom), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (response_chunks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_register(input logic [1:0] index, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index == CFG_FRAME_MODE)
            mode_now = data[0];
        else if (index == CFG_SLAVE_ADDR)
            station_addr = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic mode, input logic [7:0] id);
        hold_until_drained();
        set_register(CFG_FRAME_MODE, {7'd0, mode});
        set_register(CFG_SLAVE_ADDR, id);
    endtask

    task automatic test_reset_bank();
        send_request(OP_READ, 16'd0, 16'h0000, 8'd4);
        send_request(OP_READ, 16'd0, 16'hFFFF, 8'd16);
    endtask

    task automatic test_special_cases();
        send_request(OP_WRITE, 16'd0, 16'h0000, 8'd0);
        send_request(OP_WRITE, 16'd15, 16'hFFFF, 8'd255);
        send_request(OP_READ, 16'd0, 16'h0000, 8'd16);
        send_request(OP_WRITE, 16'd16, 16'h1234, 8'd1);
        send_request(OP_WRITE, 16'hFFFF, 16'h5555, 8'd1);
        send_request(OP_READ, 16'd0, 16'h0000, 8'd0);
        send_request(OP_READ, 16'd0, 16'h0000, 8'd17);
        send_request(OP_READ, 16'hFFFF, 16'h0000, 8'd255);
        send_request(OP_READ, 16'hFFFF, 16'h0000, 8'd1);
        send_request(OP_READ, 16'd15, 16'h0000, 8'd2);
        send_request(OP_READ, 16'd15, 16'h0000, 8'd1);
        send_request(OP_READ, 16'd0, 16'hFFFF, 8'd1);
        send_request(OP_WRITE, 16'd3, 16'hA5A5, 8'hFF);
    endtask

    task automatic test_framing_modes();
        apply_settings(MODE_ASCII, 8'hFF);
        send_request(OP_WRITE, 16'd5, 16'hABCD, 8'd0);
        send_request(OP_READ, 16'd4, 16'h0000, 8'd3);
        apply_settings(MODE_ASCII, 8'h00);
        send_request(OP_WRITE, 16'd15, 16'h00FF, 8'd0);
        send_request(OP_READ, 16'd0, 16'h0000, 8'd16);
        apply_settings(MODE_RTU, 8'h00);
        send_request(OP_READ, 16'd15, 16'h0000, 8'd1);
        send_request(OP_WRITE, 16'd0, 16'h8001, 8'd0);
    endtask

    task automatic test_drain_pause();
        repeat (12) send_random_request();
        hold_until_drained();
        repeat (12) send_random_request();
    endtask

    task automatic test_random_traffic();
        int         phase;
        logic [7:0] id;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: id = 8'h01;
                1: id = 8'hFF;
                2: id = 8'h00;
                default: id = 8'($urandom_range(0, 255));
            endcase
            apply_settings(phase[0] ? MODE_ASCII : MODE_RTU, id);
            gaps_on = (phase != 3);
            repeat (PHASE_ITEMS) send_random_request();
        end
        gaps_on = 1'b1;
    endtask

    // sink side back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && gaps_on && $urandom_range(0, 99) < 15)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        chunk_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (response_chunks.size() == 0)
                report_mismatch("result transfer with nothing pending",
                                {8'd0, m_axis_tdata}, 32'd0);
            else
            begin
                want = response_chunks.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[7:0] !== want.byte0)
                    report_mismatch("first_byte", 32'(m_axis_tdata[7:0]), 32'(want.byte0));
                if (m_axis_tdata[15:8] !== want.byte1)
                    report_mismatch("second_byte", 32'(m_axis_tdata[15:8]),
                                    32'(want.byte1));
                if (m_axis_tdata[17:16] !== want.nbytes)
                    report_mismatch("byte_count", 32'(m_axis_tdata[17:16]),
                                    32'(want.nbytes));
                if (m_axis_tdata[23:18] !== 6'd0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[23:18]), 32'd0);
                if (m_axis_tlast !== want.is_last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(want.is_last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int i;
        for (i = 0; i < REGS; i++)
            holding_regs[i] = (i < 4) ? 16'(100 * (i + 1)) : 16'd0;
        mode_now = MODE_RTU;
        station_addr = 8'd1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_bank();
        test_special_cases();
        test_framing_modes();
        test_drain_pause();
        test_random_traffic();

        hold_until_drained();
        repeat (120) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/mbsr_pkg.sv
src/mbsr_bank.sv
src/mbsr_seq.sv
src/mbsr_packer.sv
src/modbus_slave_register_responder_unit.sv
src/mbsr_checker.sv
sim/testbench.sv
